// ===== src/smf_pkg.sv =====
`timescale 1ns / 1ps

package smf_pkg;

	// Fixed field widths
	localparam int DATA_W            = 16;
	localparam int CFG_W             = 5;

	// Defaults
	localparam int MAX_WINDOW_DEF    = 16;
	localparam int WINDOW_LENGTH_RST = 5;

	// Control from the sequencer to the sort array
	typedef struct packed {
		logic              clear;   // empty the sorted list
		logic              insert;  // insert data into the sorted list
		logic [DATA_W-1:0] data;
	} sort_ctl_t;

endpackage

// ===== src/smf_window_mem.sv =====
`timescale 1ns / 1ps

module smf_window_mem
	import smf_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [MAX_WINDOW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, enabled by re
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/smf_sorter.sv =====
`timescale 1ns / 1ps

module smf_sorter
	import smf_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
	localparam int CW = $clog2(MAX_WINDOW + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sort_ctl_t         ctl,
	input  logic [AW-1:0]     sel_idx,
	output logic [CW-1:0]     count,
	output logic [DATA_W-1:0] sel_data
);

	logic [DATA_W-1:0] list_q [MAX_WINDOW];
	logic [DATA_W-1:0] list_d [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] gt;
	logic [CW-1:0] cnt_q;

	// gt[m]: slot m holds a larger value or is empty; monotone over m
	always_comb begin
		for (int m = 0; m < MAX_WINDOW; m++) begin
			gt[m] = (CW'(m) >= cnt_q) || (list_q[m] > ctl.data);
		end
		for (int m = 0; m < MAX_WINDOW; m++) begin
			if (!gt[m]) begin
				list_d[m] = list_q[m];
			end else if (m > 0 && gt[(m > 0) ? m - 1 : 0]) begin
				list_d[m] = list_q[(m > 0) ? m - 1 : 0];
			end else begin
				list_d[m] = ctl.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			list_q <= list_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
		end else if (ctl.insert && cnt_q < CW'(MAX_WINDOW)) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign count    = cnt_q;
	assign sel_data = list_q[sel_idx];

	generate
		if (MAX_WINDOW > 1) begin : g_order_chk
			a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
				(cnt_q >= CW'(2)) |-> (list_q[0] <= list_q[1]))
				else $error("sort list head out of order");
		end
	endgenerate

endmodule

// ===== src/sliding_median_filter.sv =====
`timescale 1ns / 1ps
// Sliding median filter: running median over the last window_length samples of a record.
// A transaction that yields a result blocks further input until its pass ends
//   (one store read per window entry, then the median goes to the output register);
//   transactions that yield none are taken one per cycle.
// Reset (arst_n low, asynchronous): window empty, write slot 0, window_length 5,
//   no result pending; the sample store itself is not cleared.

module sliding_median_filter
	import smf_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] sample,
	input  logic              last_sample,
	// output channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] median,
	output logic              is_last
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;  // take transactions, write store
	localparam logic [1:0] S_READ = 2'd1;  // one store read per window entry
	localparam logic [1:0] S_WAIT = 2'd2;  // last read data goes into the sorter
	localparam logic [1:0] S_FIN  = 2'd3;  // hand median to the output register

	logic [1:0]        state_q;
	logic [CFG_W-1:0]  cfg_len_q;
	logic [AW-1:0]     wp_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     len_q;      // window length latched for the current pass
	logic [AW-1:0]     rd_addr_q;
	logic [CW-1:0]     rd_cnt_q;
	logic              last_q;
	logic              rd_vld_s1;
	logic              out_valid_q;
	logic [DATA_W-1:0] median_q;
	logic              is_last_q;

	logic [CW-1:0]     eff_len;
	logic [CW-1:0]     fill_next;
	logic              has_result;
	logic              in_fire;
	logic              out_load;
	logic              mem_re;
	logic [DATA_W-1:0] mem_rdata;
	logic [CW-1:0]     sort_cnt;
	logic [DATA_W-1:0] sort_sel;
	sort_ctl_t         sort_ctl;

	// Register value 0 acts as 1; values above the store depth clamp to it.
	always_comb begin
		if (cfg_len_q == '0) begin
			eff_len = CW'(1);
		end else if (int'(cfg_len_q) > MAX_WINDOW) begin
			eff_len = CW'(MAX_WINDOW);
		end else begin
			eff_len = CW'(cfg_len_q);
		end
	end

	// fill count saturates at the store depth
	assign fill_next  = (fill_q < CW'(MAX_WINDOW)) ? fill_q + CW'(1) : fill_q;
	assign has_result = (fill_next >= eff_len);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign mem_re   = (state_q == S_READ);

	// Store writes only happen in S_IDLE and reads only in S_READ, so a read
	// never overlaps a write to the same slot; the write lands before the
	// first read of the pass.
	smf_window_mem #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_mem (
		.clk   (clk),
		.we    (in_fire),
		.waddr (wp_q),
		.wdata (sample),
		.re    (mem_re),
		.raddr (rd_addr_q),
		.rdata (mem_rdata)
	);

	assign sort_ctl.clear  = in_fire && has_result;
	assign sort_ctl.insert = rd_vld_s1;
	assign sort_ctl.data   = mem_rdata;

	// Insertion sort in a register list, one store entry per cycle.
	smf_sorter #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_sort (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sort_ctl),
		.sel_idx  (AW'(len_q >> 1)),
		.count    (sort_cnt),
		.sel_data (sort_sel)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q <= CFG_W'(WINDOW_LENGTH_RST);
		end else if (cfg_wr_en) begin
			cfg_len_q <= cfg_wr_data;
		end
	end

	// Window bookkeeping: write slot wraps at the store depth, a record end
	// restarts both slot and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (in_fire) begin
			if (last_sample) begin
				wp_q   <= '0;
				fill_q <= '0;
			end else begin
				wp_q   <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
				fill_q <= fill_next;
			end
		end
	end

	// Sequencer: walks the store backward from the newest sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && has_result) begin
						state_q  <= S_READ;
						rd_cnt_q <= '0;
					end
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + CW'(1);
					if (rd_cnt_q == len_q - CW'(1)) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-pass payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			len_q     <= eff_len;
			rd_addr_q <= wp_q;
			last_q    <= last_sample;
		end else if (mem_re) begin
			rd_addr_q <= (rd_addr_q == '0) ? AW'(MAX_WINDOW - 1) : rd_addr_q - AW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			median_q  <= sort_sel;
			is_last_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;
	assign is_last   = is_last_q;

	// the sorter must hold exactly one full window when the median is taken
	a_full_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (sort_cnt == len_q))
		else $error("median taken from a partly filled sort list");

	// a record end restarts the window
	a_record_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_sample) |=> (fill_q == '0 && wp_q == '0))
		else $error("window not restarted after record end");

	// read data only returns while a pass is running
	a_read_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_READ || state_q == S_WAIT))
		else $error("store read data outside a pass");

endmodule

// ===== test/sliding_median_filter_tb.sv =====
`timescale 1ns / 1ps
// Running median filter testbench.
// - Input transactions are predicted as they are accepted; expected results wait in a queue.
// - Every output transaction is checked field by field against the oldest expectation.
// - The window length is only rewritten when nothing is in flight.

module sliding_median_filter_tb;
	import smf_pkg::*;

	// Long enough for a result pass to finish, with room to spare
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 60;

	typedef struct packed {
		logic [DATA_W-1:0] median;
		logic              is_last;
	} median_res_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CFG_W-1:0]  cfg_wr_data;
	logic              in_valid;
	logic              in_ready;
	logic [DATA_W-1:0] sample;
	logic              last_sample;
	logic              out_valid;
	logic              out_ready;
	logic [DATA_W-1:0] median;
	logic              is_last;

	// Medians still to come, oldest first
	median_res_t median_q[$];

	// Own copy of the filter state: sample history, fill level, next slot, length
	logic [DATA_W-1:0] hist_mem [MAX_WINDOW_DEF];
	int                hist_cnt    = 0;
	int                hist_wp     = 0;
	logic [CFG_W-1:0]  win_len_cfg = CFG_W'(WINDOW_LENGTH_RST);

	int err_cnt  = 0;
	bit idle_on  = 1'b1;  // random idling on both sides
	int rec_left = 0;     // samples left in the record being sent

	sliding_median_filter #(
		.MAX_WINDOW(MAX_WINDOW_DEF)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.last_sample (last_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.median      (median),
		.is_last     (is_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	// Length 0 behaves as 1, anything above the store depth as the full store
	function automatic int clamp_length(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_WINDOW_DEF)
			return MAX_WINDOW_DEF;
		return int'(v);
	endfunction

	// Sort the newest len samples and take index len/2 (upper middle when even)
	function automatic logic [DATA_W-1:0] window_median(int len);
		logic [DATA_W-1:0] win [MAX_WINDOW_DEF];
		logic [DATA_W-1:0] t;
		int                i;
		int                j;
		for (i = 0; i < len; i++)
			win[i] = hist_mem[(hist_wp + MAX_WINDOW_DEF - 1 - i) % MAX_WINDOW_DEF];
		for (i = 0; i < len; i++)
			for (j = i + 1; j < len; j++)
				if (win[j] < win[i]) begin
					t      = win[i];
					win[i] = win[j];
					win[j] = t;
				end
		return win[len / 2];
	endfunction

	task automatic take_sample(input logic [DATA_W-1:0] s, input logic l);
		int          len;
		median_res_t r;
		len               = clamp_length(win_len_cfg);
		hist_mem[hist_wp] = s;
		hist_wp           = (hist_wp + 1) % MAX_WINDOW_DEF;
		if (hist_cnt < MAX_WINDOW_DEF)
			hist_cnt++;
		// a record shorter than the window never yields a median
		if (hist_cnt >= len) begin
			r.median  = window_median(len);
			r.is_last = l;
			median_q.push_back(r);
		end
		// end of record: next sample starts an empty window
		if (l) begin
			hist_cnt = 0;
			hist_wp  = 0;
		end
	endtask

	task automatic report_mismatch(input string what);
		err_cnt++;
		if (err_cnt <= 100)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// ---------------------------------------------------------------
	// Monitor: predict on input transactions, check output transactions.
	// Values read here are those before the edge.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : median_mon
		median_res_t want;
		if (in_valid && in_ready)
			take_sample(sample, last_sample);
		if (out_valid && out_ready) begin
			if (median_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result median=%h is_last=%b",
					median, is_last));
			end else begin
				want = median_q.pop_front();
				if (median !== want.median)
					report_mismatch($sformatf("median %h, expected %h", median, want.median));
				if (is_last !== want.is_last)
					report_mismatch($sformatf("is_last %b, expected %b (median %h)",
						is_last, want.is_last, want.median));
			end
		end
	end

	// Result side: random stall bursts while idling is on
	initial begin : out_stall
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// ---------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------

	// Called right after a rising edge; returns at the edge that accepts the transaction.
	// Valid stays high afterwards so back-to-back transactions need no toggling.
	task automatic send_sample(input logic [DATA_W-1:0] s, input logic l);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample      <= s;
		last_sample <= l;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Stop sending, let every expected median arrive, then let items with no
	// result finish inside the block
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (median_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window_length(input logic [CFG_W-1:0] v);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		win_len_cfg  = v;
	endtask

	// Mix of extremes, a narrow band for duplicates, and full-range values
	function automatic logic [DATA_W-1:0] rand_sample();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return $urandom_range(0, 1) ? {DATA_W{1'b1}} : '0;
		if (pick <= 3)
			return DATA_W'($urandom_range(100, 107));
		return DATA_W'($urandom_range(0, 65535));
	endfunction

	// Mostly records long enough to produce medians; a few short ones
	function automatic int plan_record();
		int len;
		int pick;
		len  = clamp_length(win_len_cfg);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return $urandom_range(1, len);
		if (pick == 1)
			return 1;
		return len + $urandom_range(0, 24);
	endfunction

	// A record left open here carries over into the next length setting
	task automatic send_records(input int n_items);
		int k;
		for (k = 0; k < n_items; k++) begin
			if (rec_left == 0)
				rec_left = plan_record();
			rec_left--;
			send_sample(rand_sample(), rec_left == 0);
		end
	endtask

	function automatic logic [CFG_W-1:0] phase_length(input int ph);
		case (ph)
			0:       return CFG_W'(16);
			1:       return CFG_W'(31);  // above depth, acts as 16
			2:       return CFG_W'(1);
			3:       return CFG_W'(17);
			4:       return CFG_W'(2);
			5:       return CFG_W'(0);   // acts as 1
			6:       return CFG_W'(9);
			default: return CFG_W'($urandom_range(0, 31));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset length 5 with extreme and alternating bit patterns
	task automatic test_reset_length();
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'h5555, 1'b0);
		send_sample(16'h8001, 1'b0);
		send_sample(16'h7FFE, 1'b1);
	endtask

	// Record ends before the window fills: no result at all
	task automatic test_short_record();
		send_sample(16'h0042, 1'b0);
		send_sample(16'hFFFE, 1'b1);
	endtask

	// Length zero behaves as one: every sample is its own median
	task automatic test_length_zero();
		set_window_length('0);
		send_sample(16'h1234, 1'b0);
		send_sample(16'hFFFF, 1'b1);
	endtask

	// Even length picks the upper middle; the length grows with the record open
	task automatic test_length_change();
		set_window_length(CFG_W'(2));
		send_sample(16'd3, 1'b0);
		send_sample(16'd9, 1'b0);
		set_window_length(CFG_W'(4));
		send_sample(16'd1, 1'b0);
		send_sample(16'd7, 1'b1);
	endtask

	// Random records over several lengths; the last phases run without idling
	task automatic test_random();
		int ph;
		for (ph = 0; ph < PHASES; ph++) begin
			set_window_length(phase_length(ph));
			idle_on = (ph < PHASES - 2);
			send_records(PHASE_ITEMS);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		sample      = '0;
		last_sample = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_length();
		test_short_record();
		test_length_zero();
		test_length_change();
		test_random();

		wait_idle();
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
